// ===== src/rbc_pkg.sv =====
// Shared constants, codes, state types and structs for the rank-biserial unit.
// No dependencies; every other file in src imports this package.
package rbc_pkg;

   localparam int MAX_ITEMS = 1024;
   localparam int ADDR_W    = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int KEY_W     = 32;
   localparam int GRP_W     = 2;
   localparam int CORR_W    = 18;
   localparam int STAT_W    = 2;
   localparam int FRAC_BITS = 16;

   localparam int REQ_DATA_W = ((KEY_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((CORR_W + 7) / 8) * 8;

   // rank sums and products
   localparam int SUM_W  = 2 * ADDR_W;
   localparam int PROD_W = SUM_W + CNT_W;
   localparam int REM_W  = PROD_W + 2;
   localparam int QT_W   = FRAC_BITS + 2;
   localparam int STEP_W = $clog2(QT_W);

   localparam int CORR_MAX = 2 ** (CORR_W - 1) - 1;

   localparam logic [GRP_W-1:0] GRP_ZERO = 2'd0;
   localparam logic [GRP_W-1:0] GRP_ONE  = 2'd1;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_OVFL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_RANK,
      ST_ARITH,
      ST_OUT
   } top_state_type;

   typedef enum logic [2:0] {
      RK_IDLE,
      RK_RD_I,
      RK_GET_I,
      RK_SCAN,
      RK_NEXT,
      RK_DONE
   } rank_state_type;

   typedef enum logic [3:0] {
      AR_IDLE,
      AR_MUL_A,
      AR_MUL_B,
      AR_MUL_P,
      AR_MUL_D,
      AR_SUB,
      AR_DIV,
      AR_RND,
      AR_DONE
   } arith_state_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [KEY_W-1:0]  key;
      logic [GRP_W-1:0]  grp;
   } wr_req_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum0;
      logic [CNT_W-1:0] cnt0;
      logic [SUM_W-1:0] sum1;
      logic [CNT_W-1:0] cnt1;
   } sums_type;

   typedef struct packed {
      logic     done;
      sums_type sums;
   } rank_res_type;

endpackage

// ===== src/rbc_rank.sv =====
// Item store and ranking sequencer: one key compare per cycle over the stored set.
// Depends on rbc_pkg.
module rbc_rank (
   input  logic                      clock,
   input  logic                      reset,
   input  rbc_pkg::wr_req_type       wr,
   input  logic                      start,
   input  logic [rbc_pkg::CNT_W-1:0] n,
   output rbc_pkg::rank_res_type     res
);
   import rbc_pkg::*;

   logic [KEY_W-1:0] key_mem [MAX_ITEMS];
   logic [GRP_W-1:0] grp_mem [MAX_ITEMS];
   logic [KEY_W-1:0] rd_key_ff;
   logic [GRP_W-1:0] rd_grp_ff;
   logic [ADDR_W-1:0] rd_addr;

   rank_state_type state_ff, state_in;
   logic [CNT_W-1:0]  i_ff, i_in, j_ff, j_in;
   logic [ADDR_W-1:0] rank_ff, rank_in;
   logic              pend_ff, pend_in;
   logic [KEY_W-1:0]  ki_ff, ki_in;
   logic              gi_ff, gi_in;
   sums_type          sums_ff, sums_in;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         key_mem[wr.addr] <= wr.key;
         grp_mem[wr.addr] <= wr.grp;
      end
      rd_key_ff <= key_mem[rd_addr];
      rd_grp_ff <= grp_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RK_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      rank_ff <= rank_in;
      ki_ff   <= ki_in;
      gi_ff   <= gi_in;
      sums_ff <= sums_in;
   end

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      rank_in  = rank_ff;
      pend_in  = pend_ff;
      ki_in    = ki_ff;
      gi_in    = gi_ff;
      sums_in  = sums_ff;
      rd_addr  = i_ff[ADDR_W-1:0];
      case (state_ff)
         RK_IDLE: begin
            if (start) begin
               i_in     = '0;
               sums_in  = '0;
               state_in = RK_RD_I;
            end
         end
         RK_RD_I: begin
            state_in = RK_GET_I;
         end
         RK_GET_I: begin
            ki_in = rd_key_ff;
            gi_in = (rd_grp_ff == GRP_ONE);
            if (rd_grp_ff inside {GRP_ZERO, GRP_ONE}) begin
               j_in     = '0;
               rank_in  = '0;
               pend_in  = 1'b0;
               state_in = RK_SCAN;
            end else begin
               state_in = RK_NEXT;
            end
         end
         RK_SCAN: begin
            rd_addr = j_ff[ADDR_W-1:0];
            pend_in = (j_ff != n);
            if (j_ff != n) begin
               j_in = j_ff + CNT_W'(1);
            end
            if (pend_ff && ($signed(rd_key_ff) < $signed(ki_ff))) begin
               rank_in = rank_ff + ADDR_W'(1);
            end
            if (j_ff == n && !pend_ff) begin
               if (gi_ff) begin
                  sums_in.sum1 = sums_ff.sum1 + SUM_W'(rank_ff);
                  sums_in.cnt1 = sums_ff.cnt1 + CNT_W'(1);
               end else begin
                  sums_in.sum0 = sums_ff.sum0 + SUM_W'(rank_ff);
                  sums_in.cnt0 = sums_ff.cnt0 + CNT_W'(1);
               end
               state_in = RK_NEXT;
            end
         end
         RK_NEXT: begin
            i_in = i_ff + CNT_W'(1);
            if (i_ff + CNT_W'(1) == n) begin
               state_in = RK_DONE;
            end else begin
               state_in = RK_RD_I;
            end
         end
         RK_DONE: begin
            state_in = RK_IDLE;
         end
         default: begin
            state_in = RK_IDLE;
         end
      endcase
   end

   assign res.done = (state_ff == RK_DONE);
   assign res.sums = sums_ff;

endmodule

// ===== src/rbc_arith.sv =====
// Coefficient sequencer: one shared multiplier, then a restoring divider
// producing one quotient bit per cycle, rounding and saturation. Depends on rbc_pkg.
module rbc_arith (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [rbc_pkg::CNT_W-1:0]  n,
   input  rbc_pkg::sums_type          sums,
   output logic                       done,
   output logic [rbc_pkg::CORR_W-1:0] corr
);
   import rbc_pkg::*;

   arith_state_type state_ff, state_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [PROD_W-1:0] a_ff, a_in, b_ff, b_in, den_ff, den_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [QT_W-1:0]   q_ff, q_in;
   logic              neg_ff, neg_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CORR_W-1:0] corr_ff, corr_in;

   logic [SUM_W-1:0]  mul_a;
   logic [CNT_W-1:0]  mul_b;
   logic [PROD_W-1:0] mul_p;
   logic [PROD_W-1:0] mag;
   logic [REM_W-1:0]  trial, diff;
   logic              ge;
   logic [QT_W:0]     qsum;
   logic [QT_W-1:0]   qr;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      neg_ff  <= neg_in;
      step_ff <= step_in;
      corr_ff <= corr_in;
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_a = sums.sum1;
      mul_b = sums.cnt0;
      case (state_ff)
         AR_MUL_B: begin
            mul_a = sums.sum0;
            mul_b = sums.cnt1;
         end
         AR_MUL_P: begin
            mul_a = SUM_W'(sums.cnt0);
            mul_b = sums.cnt1;
         end
         AR_MUL_D: begin
            mul_a = prod_ff[SUM_W-1:0];
            mul_b = n;
         end
         default: begin
         end
      endcase
   end

   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign trial = (step_ff == '0) ? rem_ff : {rem_ff[REM_W-2:0], 1'b0};
   assign ge    = (trial >= REM_W'(den_ff));
   assign diff  = trial - REM_W'(den_ff);
   assign mag   = (a_ff < b_ff) ? (b_ff - a_ff) : (a_ff - b_ff);
   assign qsum  = {1'b0, q_ff} + (QT_W+1)'(1);
   assign qr    = qsum[QT_W:1];

   always_comb begin
      state_in = state_ff;
      prod_in  = prod_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      neg_in   = neg_ff;
      step_in  = step_ff;
      corr_in  = corr_ff;
      done     = 1'b0;
      case (state_ff)
         AR_IDLE: begin
            if (start) begin
               state_in = AR_MUL_A;
            end
         end
         AR_MUL_A: begin
            prod_in  = mul_p;
            state_in = AR_MUL_B;
         end
         AR_MUL_B: begin
            a_in     = prod_ff;
            prod_in  = mul_p;
            state_in = AR_MUL_P;
         end
         AR_MUL_P: begin
            b_in     = prod_ff;
            prod_in  = mul_p;
            state_in = AR_MUL_D;
         end
         AR_MUL_D: begin
            prod_in  = mul_p;
            state_in = AR_SUB;
         end
         AR_SUB: begin
            den_in   = prod_ff;
            neg_in   = (a_ff < b_ff);
            rem_in   = {1'b0, mag, 1'b0};
            q_in     = '0;
            step_in  = '0;
            state_in = AR_DIV;
         end
         AR_DIV: begin
            rem_in  = ge ? diff : trial;
            q_in    = {q_ff[QT_W-2:0], ge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(QT_W - 1)) begin
               state_in = AR_RND;
            end
         end
         AR_RND: begin
            if (!neg_ff) begin
               corr_in = (qr > QT_W'(CORR_MAX)) ? CORR_W'(CORR_MAX) : qr[CORR_W-1:0];
            end else if (qr > QT_W'(CORR_MAX + 1)) begin
               corr_in = CORR_W'(0) - CORR_W'(CORR_MAX + 1);
            end else begin
               corr_in = CORR_W'(0) - qr[CORR_W-1:0];
            end
            state_in = AR_DONE;
         end
         AR_DONE: begin
            done     = 1'b1;
            state_in = AR_IDLE;
         end
         default: begin
            state_in = AR_IDLE;
         end
      endcase
   end

   assign corr = corr_ff;

endmodule

// ===== src/rank_biserial_correlation_unit.sv =====
// Rank-biserial correlation unit: control sequencer and result register.
// Depends on rbc_pkg, rbc_rank and rbc_arith.
//
// Usage: requests arrive on the req_ channel, one request per handshake:
// req_tdata carries the signed key, req_tuser the group code, req_tlast marks
// the last item of a set. Items load at one per cycle into a 1024-entry store.
// After the last item the block drops req_tready while it ranks the set: each
// group-0 or group-1 item takes one key compare per cycle against the store's
// single read port; other items are not ranked. The shared multiplier
// and a one-bit-per-cycle divider then form the coefficient. One result per
// set leaves on rsp_: rsp_tdata carries the Q2.16 coefficient, rsp_tuser the
// status (ok, group empty, overflow). Overflowed sets skip ranking and go
// straight to the output stage; sets with an empty group finish right after ranking.
// A result waits in an output register while rsp_tready is low; the next set
// loads meanwhile, and the block only stalls before writing a second result.
// Reset (synchronous, active high) empties the set and the output register;
// the store contents are not cleared.
module rank_biserial_correlation_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [rbc_pkg::REQ_DATA_W-1:0] req_tdata,   // [31:0] key_value
   input  logic [rbc_pkg::GRP_W-1:0]      req_tuser,   // [1:0] group_code
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rbc_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [17:0] correlation
   output logic [rbc_pkg::STAT_W-1:0]     rsp_tuser    // [1:0] status
);
   import rbc_pkg::*;

   top_state_type state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic              rank_start_ff, rank_start_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CORR_W-1:0] res_corr_ff, res_corr_in, rsp_corr_ff;
   status_type        res_stat_ff, res_stat_in, rsp_stat_ff;

   logic              req_acc, room, rsp_load, arith_start, arith_done;
   logic [CORR_W-1:0] arith_corr;
   wr_req_type        wr;
   rank_res_type      rank_res;

   rbc_rank u_rank (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .start (rank_start_ff),
      .n     (count_ff),
      .res   (rank_res)
   );

   rbc_arith u_arith (
      .clock (clock),
      .reset (reset),
      .start (arith_start),
      .n     (count_ff),
      .sums  (rank_res.sums),
      .done  (arith_done),
      .corr  (arith_corr)
   );

   assign req_tready = (state_ff == ST_LOAD);
   assign req_acc    = req_tvalid && req_tready;
   assign room       = (count_ff < CNT_W'(MAX_ITEMS));

   assign wr.en   = req_acc && room;
   assign wr.addr = count_ff[ADDR_W-1:0];
   assign wr.key  = req_tdata[KEY_W-1:0];
   assign wr.grp  = req_tuser;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         rank_start_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         rank_start_ff <= rank_start_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_corr_ff <= res_corr_in;
      res_stat_ff <= res_stat_in;
      if (rsp_load) begin
         rsp_corr_ff <= res_corr_ff;
         rsp_stat_ff <= res_stat_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      rank_start_in = 1'b0;
      res_corr_in   = res_corr_ff;
      res_stat_in   = res_stat_ff;
      arith_start   = 1'b0;
      rsp_load      = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               if (room) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  if (ovf_ff || !room) begin
                     res_corr_in = '0;
                     res_stat_in = STAT_OVFL;
                     state_in    = ST_OUT;
                  end else begin
                     rank_start_in = 1'b1;
                     state_in      = ST_RANK;
                  end
               end
            end
         end
         ST_RANK: begin
            if (rank_res.done) begin
               if (rank_res.sums.cnt0 == '0 || rank_res.sums.cnt1 == '0) begin
                  res_corr_in = '0;
                  res_stat_in = STAT_EMPTY;
                  state_in    = ST_OUT;
               end else begin
                  arith_start = 1'b1;
                  state_in    = ST_ARITH;
               end
            end
         end
         ST_ARITH: begin
            if (arith_done) begin
               res_corr_in = arith_corr;
               res_stat_in = STAT_OK;
               state_in    = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_corr_ff);
   assign rsp_tuser  = rsp_stat_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("item count beyond store depth");

   a_rank_done_state: assert property (@(posedge clock) disable iff (reset)
      rank_res.done |-> state_ff == ST_RANK)
      else $error("ranking finished outside the rank phase");

   a_arith_done_state: assert property (@(posedge clock) disable iff (reset)
      arith_done |-> state_ff == ST_ARITH)
      else $error("divider finished outside the arithmetic phase");

   a_bad_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STAT_OK |-> rsp_tdata[CORR_W-1:0] == '0)
      else $error("nonzero coefficient with error status");

endmodule

// ===== tb/rank_biserial_correlation_unit_tb.sv =====
// Testbench for rank_biserial_correlation_unit: item sets on the request stream, coefficient
// and status checked against an internal rank predictor kept in a small scoreboard class.
// Depends on rbc_pkg and the unit itself.
`timescale 1ns / 100ps

module rank_biserial_correlation_unit_tb;
   import rbc_pkg::*;

   localparam int          STALL_LIMIT = 40000;
   localparam int          HOLD_LEN    = 400;
   localparam logic [31:0] KEY_MIN     = 32'h8000_0000;
   localparam logic [31:0] KEY_MAX     = 32'h7FFF_FFFF;
   localparam logic [1:0]  GRP_OTHER   = 2'd2;
   localparam logic [1:0]  GRP_SPARE   = 2'd3;
   localparam int          KEYS_WIDE   = 0;
   localparam int          KEYS_TIED   = 1;
   localparam int          KEYS_EDGE   = 2;

   typedef struct {
      logic [CORR_W-1:0] corr;
      status_type        status;
   } coeff_result_type;

   class rank_corr_scoreboard_type;
      int               set_keys[$];
      logic [1:0]       set_groups[$];
      bit               set_overflow;
      coeff_result_type expected_coeffs[$];
      int               errors;

      function coeff_result_type predict_coefficient();
         coeff_result_type r;
         longint unsigned  sum0, sum1, cnt0, cnt1, rank, a, b, mag, den, q;
         bit               neg;
         int               n;
         r.corr = '0;
         r.status = STAT_OK;
         n = set_keys.size();
         sum0 = 0; sum1 = 0; cnt0 = 0; cnt1 = 0;
         if (set_overflow) begin
            r.status = STAT_OVFL;
            return r;
         end
         for (int i = 0; i < n; i++) begin
            if (!(set_groups[i] inside {GRP_ZERO, GRP_ONE})) continue;
            rank = 0;
            for (int j = 0; j < n; j++)
               if (set_keys[j] < set_keys[i]) rank++;
            if (set_groups[i] == GRP_ZERO) begin
               sum0 += rank;
               cnt0++;
            end else begin
               sum1 += rank;
               cnt1++;
            end
         end
         if (cnt0 == 0 || cnt1 == 0) begin
            r.status = STAT_EMPTY;
            return r;
         end
         // 2*(mean1-mean0)/n = 2*(sum1*cnt0 - sum0*cnt1) / (cnt0*cnt1*n)
         a = sum1 * cnt0;
         b = sum0 * cnt1;
         neg = a < b;
         mag = neg ? b - a : a - b;
         den = cnt0 * cnt1 * longint'(n);
         q = ((mag << 1) << (FRAC_BITS + 1)) / den;
         q = (q + 1) >> 1;
         if (!neg) begin
            if (q > CORR_MAX) q = CORR_MAX;
            r.corr = q[CORR_W-1:0];
         end else begin
            if (q > CORR_MAX + 1) q = CORR_MAX + 1;
            r.corr = -q[CORR_W-1:0];
         end
         return r;
      endfunction

      function void note_request(logic [31:0] key, logic [1:0] grp, bit last);
         if (set_keys.size() < MAX_ITEMS) begin
            set_keys = {set_keys, $signed(key)};
            set_groups = {set_groups, grp};
         end else begin
            set_overflow = 1'b1;
         end
         if (last) begin
            expected_coeffs = {expected_coeffs, predict_coefficient()};
            set_keys.delete();
            set_groups.delete();
            set_overflow = 1'b0;
         end
      endfunction

      function void check_result(logic [CORR_W-1:0] corr, logic [STAT_W-1:0] stat);
         coeff_result_type want;
         if (expected_coeffs.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual corr %h status %0d",
                     $time, corr, stat);
            return;
         end
         want = expected_coeffs.pop_front();
         if (corr !== want.corr) begin
            errors++;
            $display("%0t: correlation expected %h actual %h", $time, want.corr, corr);
         end
         if (stat !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, stat);
         end
      endfunction

      function int pending();
         return expected_coeffs.size();
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [GRP_W-1:0]      req_tuser  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0]     rsp_tuser;

   bit   idle_on   = 1'b1;
   bit   hold_req  = 1'b0;
   bit   hold_done = 1'b0;
   int   hold_left = 0;

   logic [31:0] set_key_q[$];
   logic [1:0]  set_grp_q[$];

   rank_corr_scoreboard_type sb = new();

   rank_biserial_correlation_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   task automatic send_item(input logic [31:0] key, input logic [1:0] grp, input bit last);
      while (idle_on && $urandom_range(0, 99) < 15) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      req_tuser  <= grp;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_request(key, grp, last);
   endtask

   task automatic add_item(input logic [31:0] key, input logic [1:0] grp);
      set_key_q = {set_key_q, key};
      set_grp_q = {set_grp_q, grp};
   endtask

   task automatic send_set();
      for (int i = 0; i < set_key_q.size(); i++)
         send_item(set_key_q[i], set_grp_q[i], i == set_key_q.size() - 1);
      set_key_q.delete();
      set_grp_q.delete();
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function automatic logic [31:0] rand_key(int mode);
      case (mode)
         KEYS_TIED: return 32'(int'($urandom_range(0, 8)) - 4);
         KEYS_EDGE: begin
            case ($urandom_range(0, 3))
               0: return KEY_MIN;
               1: return KEY_MAX;
               2: return 32'h0;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [1:0] rand_group();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return GRP_ZERO;
      if (r < 90) return GRP_ONE;
      return ($urandom_range(0, 1) != 0) ? GRP_SPARE : GRP_OTHER;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata[CORR_W-1:0], rsp_tuser);
         if (hold_req && !hold_done) begin
            hold_left = HOLD_LEN;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(idle_on && $urandom_range(0, 99) < 15);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int n_items, set_no, size, mode;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes: full-scale positive and negative
      add_item(KEY_MIN, GRP_ZERO); add_item(KEY_MAX, GRP_ONE); send_set();
      add_item(KEY_MAX, GRP_ZERO); add_item(KEY_MIN, GRP_ONE);
      add_item(32'h0, GRP_OTHER); add_item(32'hFFFF_FFFF, GRP_SPARE); send_set();
      // all keys tied
      add_item(32'd5, GRP_ZERO); add_item(32'd5, GRP_ONE); add_item(32'd5, GRP_ZERO); send_set();
      // empty group cases
      add_item(32'd1, GRP_ONE); add_item(32'd2, GRP_ONE); add_item(32'd3, GRP_OTHER); send_set();
      add_item(32'd7, GRP_ZERO); send_set();
      add_item(32'hFFFF_FFFF, GRP_SPARE); send_set();
      // alternating bit patterns
      add_item(32'h5555_5555, GRP_ONE); add_item(32'hAAAA_AAAA, GRP_ZERO);
      add_item(32'h0, GRP_ONE); add_item(32'hFFFF_FFFE, GRP_ZERO);
      add_item(32'h1, GRP_OTHER); send_set();
      // fraction needs rounding
      add_item(32'd1, GRP_ZERO); add_item(32'd2, GRP_ONE); add_item(32'd3, GRP_OTHER); send_set();

      n_items = 0;
      set_no  = 0;
      while (n_items < 400) begin
         if (set_no == 4) hold_req <= 1'b1;
         if (set_no == 20) wait_drained();
         if (set_no == 30) idle_on <= 1'b0;
         if (set_no == 44) idle_on <= 1'b1;
         size = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 12);
         mode = $urandom_range(0, 2);
         repeat (size) add_item(rand_key(mode), rand_group());
         send_set();
         n_items += size;
         set_no++;
      end

      // exactly at capacity, few ranked items to keep the ranking pass short
      for (int i = 0; i < MAX_ITEMS; i++) begin
         if (i % 171 == 0)
            add_item(rand_key($urandom_range(0, 2)), ((i / 171) % 2 == 0) ? GRP_ZERO : GRP_ONE);
         else
            add_item(rand_key($urandom_range(0, 2)),
                     ($urandom_range(0, 1) != 0) ? GRP_SPARE : GRP_OTHER);
      end
      send_set();
      // over capacity, then last item itself dropped
      repeat (MAX_ITEMS + 6) add_item($urandom, rand_group());
      send_set();
      repeat (MAX_ITEMS + 1) add_item($urandom, rand_group());
      send_set();
      add_item(KEY_MIN, GRP_ONE); add_item(KEY_MAX, GRP_ZERO); send_set();

      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== rank_biserial_correlation_unit.f =====
src/rbc_pkg.sv
src/rbc_rank.sv
src/rbc_arith.sv
src/rank_biserial_correlation_unit.sv
tb/rank_biserial_correlation_unit_tb.sv
